// ===== hdl/keypad_change_reporter_macros.svh =====
// Assertion macros for the keypad change reporter.
// Depends on nothing; included by the top level.
`ifndef KEYPAD_CHANGE_REPORTER_MACROS_SVH
`define KEYPAD_CHANGE_REPORTER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define KPR_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define KPR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kpr_pkg.sv =====
// Package for the keypad change reporter: word types, codes and matrix constants.
// Depends on nothing.
`default_nettype none

package kpr_pkg;

    localparam int ROWS      = 4;
    localparam int COLS      = 4;
    localparam int KEY_COUNT = ROWS * COLS;

    // Contacts at or above KEY_COUNT are ignored.
    localparam logic [15:0] CONTACT_MASK = (KEY_COUNT >= 16) ? 16'hFFFF :
                                           16'((32'd1 << KEY_COUNT) - 32'd1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_DEMO_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEMO_PRESSES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEMO_SECONDS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CAP_ENABLE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CAP_PRESSES  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE_DELAY   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY = 3'd6;

    localparam logic [7:0] WAKE_DELAY_RESET   = 8'd2;
    localparam logic [7:0] REPEAT_DELAY_RESET = 8'd20;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_IRQ  = 1'b1;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_BLOCKED = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ticks;
        logic [31:0] clock_seconds;
        logic [31:0] uptime_seconds;
        logic [15:0] contacts;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] key_map;
        logic [31:0] stamp_seconds;
        logic [7:0]  stamp_tick;
    } out_word_t;

    // Press limits are given in tens of presses: times ten as two shifts.
    function automatic logic [19:0] times_ten(input logic [15:0] x);
        logic [19:0] w;
        begin
            w = {4'b0, x};
            times_ten = (w << 3) + (w << 1);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/keypad_change_reporter.sv =====
// keypad_change_reporter: qualifies a 4x4 key matrix and reports key map changes.
// Depends on kpr_pkg and keypad_change_reporter_macros.svh.
//
// Input channel (in_valid/in_ready/in_data): one word per tick or key interrupt.
// An interrupt word arms a wake time; a tick word at or after the wake time
// samples the contacts and, if the map changed, yields one result word.
// Output channel (out_valid/out_ready/out_data): a key record or a word that
// says the change was blocked by a usage limit.
// Config port (cfg_wr_en/cfg_index/cfg_data): single-cycle writes, write only
// while idle; indexes past the last register are dropped.
// An accepted word is held in the input register, and its result loads the
// output register once the output slot is free.
// Throughput: one word per cycle while the output slot is free; the step is a
// single pass of compares and adds between the input and output registers.
// Reset: state, limits and the pipeline clear; wake_delay resets to 2 and
// repeat_delay to 20.
// Stall: while out_ready is low the output word holds; the input register
// still takes a word if it is empty, then in_ready drops until the output frees.
`default_nettype none

`include "keypad_change_reporter_macros.svh"

module keypad_change_reporter
    import kpr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_word_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_word_t                   out_data
);

    // Configuration registers
    logic        demo_mode_reg;
    logic [15:0] demo_presses_reg;
    logic [31:0] demo_seconds_reg;
    logic        cap_enable_reg;
    logic [15:0] cap_presses_reg;
    logic [7:0]  wake_delay_reg;
    logic [7:0]  repeat_delay_reg;

    // Block state
    logic [31:0] wake_time_reg, wake_time_next;
    logic [15:0] last_map_reg, last_map_next;
    logic [31:0] press_count_reg, press_count_next;

    // Pipeline
    logic        s1_valid_reg, s1_valid_next;
    in_word_t    s1_data_reg;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    logic        out_free;
    logic        s1_fire;
    logic        sample;
    logic        emit;
    logic        blocked;
    logic [15:0] map;
    logic [31:0] demo_limit;
    logic [31:0] cap_limit;

    // Config writes: take the low bits of the data word for each register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            demo_mode_reg    <= 1'b0;
            demo_presses_reg <= '0;
            demo_seconds_reg <= '0;
            cap_enable_reg   <= 1'b0;
            cap_presses_reg  <= '0;
            wake_delay_reg   <= WAKE_DELAY_RESET;
            repeat_delay_reg <= REPEAT_DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DEMO_MODE:    demo_mode_reg    <= cfg_data[0];
                REG_DEMO_PRESSES: demo_presses_reg <= cfg_data[15:0];
                REG_DEMO_SECONDS: demo_seconds_reg <= cfg_data[31:0];
                REG_CAP_ENABLE:   cap_enable_reg   <= cfg_data[0];
                REG_CAP_PRESSES:  cap_presses_reg  <= cfg_data[15:0];
                REG_WAKE_DELAY:   wake_delay_reg   <= cfg_data[7:0];
                REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Handshake: the output slot is free when empty or being drained; the
    // input register advances into it, and refills as it advances.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Usage limits, compared against the count as it stands before this word.
    assign demo_limit = {12'b0, times_ten(demo_presses_reg)};
    assign cap_limit  = {12'b0, times_ten(cap_presses_reg)};

    always_comb
    begin
        blocked = 1'b0;
        if (demo_mode_reg &&
            ((press_count_reg >= demo_limit) ||
             (s1_data_reg.uptime_seconds >= demo_seconds_reg)))
        begin
            blocked = 1'b1;
        end
        if (cap_enable_reg && (press_count_reg >= cap_limit))
        begin
            blocked = 1'b1;
        end
    end

    // Single pass over the word in the input register.
    assign map    = s1_data_reg.contacts & CONTACT_MASK;
    assign sample = (s1_data_reg.func == FUNC_TICK) && (wake_time_reg != '0) &&
                    (s1_data_reg.now_ticks >= wake_time_reg);
    assign emit   = sample && (map != last_map_reg);

    always_comb
    begin
        wake_time_next   = wake_time_reg;
        last_map_next    = last_map_reg;
        press_count_next = press_count_reg;
        out_data_next    = out_data_reg;

        if (s1_fire)
        begin
            if (s1_data_reg.func == FUNC_IRQ)
            begin
                // Arm; a sum that wraps to zero leaves the block idle.
                wake_time_next = s1_data_reg.now_ticks + {24'b0, wake_delay_reg};
            end
            else if (sample)
            begin
                // Disarm, then re-arm while any key is held.
                wake_time_next = '0;
                if (map != '0)
                begin
                    wake_time_next = s1_data_reg.now_ticks + {24'b0, repeat_delay_reg};
                end
                if (emit)
                begin
                    last_map_next               = map;
                    out_data_next.kind          = blocked ? KIND_BLOCKED : KIND_RECORD;
                    out_data_next.key_map       = map;
                    out_data_next.stamp_seconds = s1_data_reg.clock_seconds;
                    out_data_next.stamp_tick    = s1_data_reg.now_ticks[7:0];
                    // Count records only; hold at all ones.
                    if (!blocked && (press_count_reg != '1))
                    begin
                        press_count_next = press_count_reg + 32'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (out_free)
        begin
            out_valid_next = s1_fire && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_time_reg   <= '0;
            last_map_reg    <= '0;
            press_count_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            wake_time_reg   <= wake_time_next;
            last_map_reg    <= last_map_next;
            press_count_reg <= press_count_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers: load only, no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `KPR_ASSERT_NEXT(a_count_monotonic, clk, rst_n, 1'b1,
        press_count_reg >= $past(press_count_reg), "press count went down")
    `KPR_ASSERT_IMP(a_out_from_stage, clk, rst_n, $rose(out_valid_reg),
        $past(s1_valid_reg), "result appeared without a word in the input register")
    `KPR_ASSERT_NEXT(a_record_counts, clk, rst_n,
        s1_fire && emit && !blocked && (press_count_reg != '1),
        press_count_reg == $past(press_count_reg) + 32'd1, "record did not count")
    `KPR_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !s1_valid_reg, in_ready,
        "input stalled with empty input register")

endmodule

`default_nettype wire

// ===== sim/keypad_change_reporter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for keypad_change_reporter: directed and random tick and
// interrupt words, predicted in-bench and compared word by word. Needs kpr_pkg.

module keypad_change_reporter_test;
    import kpr_pkg::*;

    // Index past the last register; writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_word_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_data;

    keypad_change_reporter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Bench copy of the registers, at their reset values.
    logic        demo_on      = 1'b0;
    logic [15:0] demo_tens    = 16'd0;
    logic [31:0] demo_secs    = 32'd0;
    logic        cap_on       = 1'b0;
    logic [15:0] cap_tens     = 16'd0;
    logic [7:0]  settle_ticks = WAKE_DELAY_RESET;
    logic [7:0]  rescan_ticks = REPEAT_DELAY_RESET;

    // Bench copy of the scanner state; a wake time of zero means disarmed.
    logic [31:0] wake_at  = 32'd0;
    logic [15:0] held_map = 16'd0;
    logic [31:0] presses  = 32'd0;

    out_word_t   expected_reports[$];
    int          errors = 0;
    bit          idle_enable = 1'b1;
    int          hold_request = 0;

    // Running tick counter and contact pattern for the random traffic.
    logic [31:0] tick_now = 32'd1000;
    logic [15:0] held_contacts = 16'd0;

    // 20 ns clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Ending guard: a hung handshake fails the run.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Work out the report for one accepted word and advance the scanner state.
    // Return 1 when the word yields a report.
    function automatic bit scan_keypad(input in_word_t w, output out_word_t rep);
        logic [15:0] map;
        logic [35:0] count_wide;
        bit          blocked;
        rep = '0;
        // An interrupt only arms; the sum wraps and a zero sum leaves it disarmed.
        if (w.func == FUNC_IRQ)
        begin
            wake_at = w.now_ticks + 32'(settle_ticks);
            return 1'b0;
        end
        if (wake_at == 32'd0 || w.now_ticks < wake_at)
            return 1'b0;
        map = w.contacts & CONTACT_MASK;
        // Keep rescanning while anything is held down.
        wake_at = (map != 16'd0) ? w.now_ticks + 32'(rescan_ticks) : 32'd0;
        if (map == held_map)
            return 1'b0;
        held_map = map;
        // Limits are in tens of presses; compare wide so nothing overflows.
        count_wide = {4'd0, presses};
        blocked = (demo_on && (count_wide >= 36'(demo_tens) * 36'd10 ||
                               w.uptime_seconds >= demo_secs)) ||
                  (cap_on && count_wide >= 36'(cap_tens) * 36'd10);
        rep.kind          = blocked ? KIND_BLOCKED : KIND_RECORD;
        rep.key_map       = map;
        rep.stamp_seconds = w.clock_seconds;
        rep.stamp_tick    = w.now_ticks[7:0];
        // Only a record counts as a press, and the count saturates.
        if (!blocked && presses != 32'hFFFF_FFFF)
            presses = presses + 32'd1;
        return 1'b1;
    endfunction

    function automatic in_word_t make_word(input logic func, input logic [31:0] now,
                                           input logic [31:0] secs, input logic [31:0] up,
                                           input logic [15:0] contacts);
        in_word_t w;
        w.func           = func;
        w.now_ticks      = now;
        w.clock_seconds  = secs;
        w.uptime_seconds = up;
        w.contacts       = contacts;
        return w;
    endfunction

    // Offer one word, optionally after a short gap, and hold it until accepted.
    // Leave valid high on return so back-to-back words need no drop.
    task automatic send_word(input in_word_t w);
        int        gap;
        out_word_t rep;
        gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (scan_keypad(w, rep))
            expected_reports.push_back(rep);
    endtask

    // Drop valid, wait out every pending report, then give the pipeline time
    // to finish words that yield nothing.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Single-cycle register write; call only after quiesce.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEMO_MODE:    demo_on      = value[0];
            REG_DEMO_PRESSES: demo_tens    = value[15:0];
            REG_DEMO_SECONDS: demo_secs    = value;
            REG_CAP_ENABLE:   cap_on       = value[0];
            REG_CAP_PRESSES:  cap_tens     = value[15:0];
            REG_WAKE_DELAY:   settle_ticks = value[7:0];
            REG_REPEAT_DELAY: rescan_ticks = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic d_on, input logic [15:0] d_tens,
                                  input logic [31:0] d_secs, input logic c_on,
                                  input logic [15:0] c_tens, input logic [7:0] wake,
                                  input logic [7:0] rescan);
        write_reg(REG_DEMO_MODE, {31'd0, d_on});
        write_reg(REG_DEMO_PRESSES, {16'd0, d_tens});
        write_reg(REG_DEMO_SECONDS, d_secs);
        write_reg(REG_CAP_ENABLE, {31'd0, c_on});
        write_reg(REG_CAP_PRESSES, {16'd0, c_tens});
        write_reg(REG_WAKE_DELAY, {24'd0, wake});
        write_reg(REG_REPEAT_DELAY, {24'd0, rescan});
    endtask

    // Mostly well-formed scanning: interrupts, then ticks marching forward with
    // held, released or changing contacts. A few words are pure noise.
    task automatic scan_traffic(input int count);
        int          pick;
        int          shape;
        logic [15:0] contacts;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                send_word(make_word(1'($urandom), $urandom, $urandom, $urandom,
                                    16'($urandom)));
            end
            else if (pick < 20)
            begin
                tick_now = tick_now + 32'($urandom_range(0, 2));
                send_word(make_word(FUNC_IRQ, tick_now, $urandom, $urandom,
                                    16'($urandom)));
            end
            else
            begin
                // Now and then jump the counter, sometimes right up to the wrap.
                if ($urandom_range(0, 99) == 0)
                    tick_now = $urandom_range(0, 1) ? 32'($urandom)
                                                     : 32'hFFFF_FF80 + 32'($urandom_range(0, 120));
                tick_now = tick_now + 32'($urandom_range(0, 4));
                shape = $urandom_range(0, 99);
                if (shape < 40)
                    contacts = held_contacts;
                else if (shape < 60)
                    contacts = 16'd0;
                else if (shape < 85)
                    contacts = 16'(1 << $urandom_range(0, 15)) | 16'(1 << $urandom_range(0, 15));
                else
                    contacts = 16'($urandom);
                held_contacts = contacts;
                send_word(make_word(FUNC_TICK, tick_now, $urandom, $urandom, contacts));
            end
        end
    endtask

    // Reset delays: arm, early tick, sample, hold, release, disarmed tick,
    // wake sum wrapping to zero, and a rescan across the counter wrap.
    task automatic test_default_delays();
        send_word(make_word(FUNC_TICK, 32'd0, 32'd0, 32'd0, 16'hFFFF));
        send_word(make_word(FUNC_IRQ, 32'd100, 32'd1, 32'd1, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd101, 32'd2, 32'd2, 16'hFFFF));
        send_word(make_word(FUNC_TICK, 32'd102, 32'hFFFF_FFFF, 32'd0, 16'hFFFF));
        send_word(make_word(FUNC_TICK, 32'd121, 32'd4, 32'd4, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd122, 32'd5, 32'd5, 16'hFFFF));
        send_word(make_word(FUNC_TICK, 32'd142, 32'd6, 32'd6, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd200, 32'd7, 32'd7, 16'h0001));
        send_word(make_word(FUNC_IRQ, 32'hFFFF_FFFE, 32'd8, 32'd8, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'hFFFF_FFFF, 32'd9, 32'd9, 16'h0005));
        send_word(make_word(FUNC_IRQ, 32'hFFFF_FFF0, 32'd10, 32'd10, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'h8000));
        send_word(make_word(FUNC_TICK, 32'd19, 32'd12, 32'd12, 16'h8001));
        quiesce();
    endtask

    // Zero delays arm at the same tick; an interrupt at tick zero stays disarmed.
    task automatic test_zero_delay();
        write_reg(REG_WAKE_DELAY, 32'd0);
        write_reg(REG_REPEAT_DELAY, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_word(make_word(FUNC_IRQ, 32'd0, 32'd20, 32'd20, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd0, 32'd21, 32'd21, 16'h0003));
        send_word(make_word(FUNC_IRQ, 32'd50, 32'd22, 32'd22, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd50, 32'd23, 32'd23, 16'h0003));
        send_word(make_word(FUNC_TICK, 32'd50, 32'd24, 32'd24, 16'h0003));
        send_word(make_word(FUNC_TICK, 32'd51, 32'd25, 32'd25, 16'h0000));
        quiesce();
    endtask

    // Demo press limit of zero, demo uptime edge, and a zero absolute cap.
    task automatic test_usage_limits();
        write_all_regs(1'b1, 16'd0, 32'd0, 1'b0, 16'd0, 8'd1, 8'd1);
        send_word(make_word(FUNC_IRQ, 32'd300, 32'd30, 32'd30, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd301, 32'd31, 32'd31, 16'h0F0F));
        send_word(make_word(FUNC_TICK, 32'd302, 32'd32, 32'd32, 16'h0000));
        quiesce();
        write_reg(REG_DEMO_PRESSES, 32'd65535);
        write_reg(REG_DEMO_SECONDS, 32'd1000);
        send_word(make_word(FUNC_IRQ, 32'd310, 32'd33, 32'd33, 16'h0000));
        send_word(make_word(FUNC_TICK, 32'd311, 32'd34, 32'd999, 16'h0001));
        send_word(make_word(FUNC_TICK, 32'd312, 32'd35, 32'd1000, 16'h0002));
        quiesce();
        write_reg(REG_DEMO_MODE, 32'd0);
        write_reg(REG_CAP_ENABLE, 32'd1);
        write_reg(REG_CAP_PRESSES, 32'd0);
        send_word(make_word(FUNC_TICK, 32'd313, 32'd36, 32'd36, 16'h0004));
        quiesce();
    endtask

    // Random traffic under a series of register settings, extremes included.
    task automatic test_random_settings();
        write_all_regs(1'b0, 16'($urandom), $urandom, 1'b0, 16'($urandom), 8'd1, 8'd1);
        scan_traffic(180);
        quiesce();
        write_all_regs(1'b1, 16'($urandom_range(0, 30)), $urandom, 1'b0, 16'd0, 8'd0, 8'd3);
        scan_traffic(140);
        quiesce();
        write_all_regs(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'd255, 8'd255);
        scan_traffic(60);
        quiesce();
        write_all_regs(1'b1, 16'hFFFF, 32'd0, 1'b1, 16'($urandom_range(0, 40)),
                       8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
        scan_traffic(120);
        quiesce();
        // Put the cap just above the current count so records turn into blocks.
        write_all_regs(1'b0, 16'd0, 32'd0, 1'b1, 16'(presses / 10 + 2),
                       WAKE_DELAY_RESET, REPEAT_DELAY_RESET);
        scan_traffic(100);
        quiesce();
    endtask

    // Stall the output long enough to fill the pipe while words keep coming,
    // then pause the input until every report is out.
    task automatic test_backpressure();
        write_all_regs(1'b0, 16'd0, 32'd0, 1'b0, 16'd0, 8'd1, 8'd1);
        tick_now = tick_now + 32'd10;
        send_word(make_word(FUNC_IRQ, tick_now, $urandom, $urandom, 16'h0000));
        hold_request = 60;
        for (int i = 0; i < 30; i++)
        begin
            tick_now = tick_now + 32'd1;
            send_word(make_word(FUNC_TICK, tick_now, $urandom, $urandom, 16'(i * 7 + 1)));
        end
        quiesce();
        scan_traffic(20);
        quiesce();
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_full_rate();
        idle_enable = 1'b0;
        write_all_regs(1'b0, 16'd0, 32'd0, 1'b0, 16'd0, 8'd1, 8'd2);
        scan_traffic(100);
    endtask

    // Output ready: random stalls, plus long hold-offs on request.
    initial
    begin : ready_driver
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 3) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
            errors++;
        end
    endtask

    // Match every report taken against the oldest prediction.
    always @(posedge clk)
    begin : report_checker
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: unexpected report, expected none, actual %h",
                         $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("kind", 32'(want.kind), 32'(out_data.kind));
                compare_field("key_map", 32'(want.key_map), 32'(out_data.key_map));
                compare_field("stamp_seconds", want.stamp_seconds, out_data.stamp_seconds);
                compare_field("stamp_tick", 32'(want.stamp_tick), 32'(out_data.stamp_tick));
            end
        end
    end

    initial
    begin : main_sequence
        int guard;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_default_delays();
        test_zero_delay();
        test_usage_limits();
        test_random_settings();
        test_backpressure();
        test_full_rate();

        // Drain what is left, with a bound so a lost report fails cleanly.
        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (expected_reports.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_reports.size() != 0)
        begin
            $display("%0t ns: %0d reports never arrived, next expected %h",
                     $time, expected_reports.size(), expected_reports[0]);
            errors++;
        end
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/kpr_pkg.sv
hdl/keypad_change_reporter.sv
sim/keypad_change_reporter_test.sv
